// ----- hdl/rmru_pkg.sv -----
`default_nettype none
package rmru_pkg;
  localparam int MaxRegions = 16;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = IdxW + 1;
  localparam int AddrW = 64;
  localparam int KindW = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_WALK,
    ST_TAIL,
    ST_SORT,
    ST_COPY,
    ST_EMIT
  } rmru_state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic walk;
    logic tail;
    logic sort;
    logic copy;
    logic emit;
  } rmru_cmd_t;

  typedef struct packed {
    logic paint;
    logic walk_done;
    logic sort_done;
    logic copy_done;
    logic emit_done;
  } rmru_sts_t;
endpackage
`default_nettype wire

// ----- hdl/region_map_range_update_top.sv -----
// After acceptance the stored regions are walked: an untouched one is pushed whole, an
// overlapped one is split into gap, lower part, painted overlap and upper part.
// Zero-length updates skip to emit; on overflow no entry is copied and the table is kept.
// Throughput: one update at a time; busy drops in the cycle that shows the last beat.
// Reset (rst_n low, synchronous) empties the table; entry storage is not cleared.
// Results cannot be stalled: each beat is shown for one cycle with out_valid.
`default_nettype none
module region_map_range_update_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_range_start,
  input  wire logic [63:0] in_range_length,
  input  wire logic [3:0]  in_range_kind,
  output logic             out_valid,
  output logic [63:0]      out_entry_start,
  output logic [63:0]      out_entry_length,
  output logic [3:0]       out_entry_kind,
  output logic [3:0]       out_entry_index,
  output logic             out_last_entry,
  output logic             out_table_empty,
  output logic             out_overflow
);
  import rmru_pkg::*;

  rmru_cmd_t cmd;
  rmru_sts_t sts;

  // sequencer: load, walk/split, tail gap, sort, commit, emit
  rmru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  // table storage, split engine, sorter and output beat register
  rmru_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_range_start(in_range_start), .in_range_length(in_range_length),
    .in_range_kind(in_range_kind), .sts(sts),
    .out_valid(out_valid), .out_entry_start(out_entry_start),
    .out_entry_length(out_entry_length), .out_entry_kind(out_entry_kind),
    .out_entry_index(out_entry_index), .out_last_entry(out_last_entry),
    .out_table_empty(out_table_empty), .out_overflow(out_overflow)
  );
endmodule
`default_nettype wire

// ----- hdl/rmru_ctrl.sv -----
`default_nettype none
module rmru_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rmru_pkg::rmru_sts_t sts,
  output logic                   busy,
  output rmru_pkg::rmru_cmd_t    cmd
);
  import rmru_pkg::*;

  rmru_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.clr = 1'b1;
        state_nxt = sts.paint ? ST_WALK : ST_EMIT;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        cmd.tail = 1'b1;
        state_nxt = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        if (sts.sort_done) state_nxt = ST_COPY;
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/rmru_dp.sv -----
`default_nettype none
module rmru_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmru_pkg::rmru_cmd_t           cmd,
  input  wire logic [rmru_pkg::AddrW-1:0]    in_range_start,
  input  wire logic [rmru_pkg::AddrW-1:0]    in_range_length,
  input  wire logic [rmru_pkg::KindW-1:0]    in_range_kind,
  output rmru_pkg::rmru_sts_t                sts,
  output logic                               out_valid,
  output logic [rmru_pkg::AddrW-1:0]         out_entry_start,
  output logic [rmru_pkg::AddrW-1:0]         out_entry_length,
  output logic [rmru_pkg::KindW-1:0]         out_entry_kind,
  output logic [3:0]                         out_entry_index,
  output logic                               out_last_entry,
  output logic                               out_table_empty,
  output logic                               out_overflow
);
  import rmru_pkg::*;

  // stored table (no reset), work table built by the walk
  logic [AddrW-1:0] tbl_s [MaxRegions];
  logic [AddrW-1:0] tbl_l [MaxRegions];
  logic [KindW-1:0] tbl_k [MaxRegions];
  logic [AddrW-1:0] wk_s [MaxRegions];
  logic [AddrW-1:0] wk_l [MaxRegions];
  logic [KindW-1:0] wk_k [MaxRegions];

  logic [CntW-1:0]  total_r, wcnt_r, idx_r;
  logic             full_r, ovf_r, odd_r;
  logic [AddrW-1:0] s_r, e_r, len_r, cur_r;
  logic [KindW-1:0] k_r;
  logic [1:0]       phase_r;  // split sub-step within one region
  logic [IdxW-1:0]  pass_r;

  // region under walk
  logic [AddrW-1:0] rs, rl, re, lo, hi;
  logic [KindW-1:0] rk;
  logic [IdxW-1:0]  ri;
  assign ri = idx_r[IdxW-1:0];
  assign rs = tbl_s[ri];
  assign rl = tbl_l[ri];
  assign rk = tbl_k[ri];
  assign re = rs + rl;
  assign lo = (rs > s_r) ? rs : s_r;
  assign hi = (re < e_r) ? re : e_r;

  logic ovl;
  assign ovl = !(re <= s_r || rs >= e_r);

  // one push per cycle
  logic             push;
  logic [AddrW-1:0] ps, pl;
  logic [KindW-1:0] pk;
  logic             adv;

  always_comb begin
    push = 1'b0; ps = '0; pl = '0; pk = '0; adv = 1'b0;
    if (cmd.walk && idx_r < total_r) begin
      if (!ovl) begin
        push = 1'b1; ps = rs; pl = rl; pk = rk; adv = 1'b1;
      end else begin
        unique case (phase_r)
          2'd0: begin
            if (rs > cur_r) begin
              push = 1'b1; ps = cur_r; pl = rs - cur_r; pk = k_r;
            end
          end
          2'd1: begin
            if (rs < lo) begin
              push = 1'b1; ps = rs; pl = lo - rs; pk = rk;
            end
          end
          2'd2: begin
            push = 1'b1; ps = lo; pl = hi - lo; pk = k_r;
          end
          default: begin
            if (hi < re) begin
              push = 1'b1; ps = hi; pl = re - hi; pk = rk;
            end
            adv = 1'b1;
          end
        endcase
      end
    end else if (cmd.tail && cur_r < e_r) begin
      push = 1'b1; ps = cur_r; pl = e_r - cur_r; pk = k_r;
    end
  end

  // odd-even transposition sort, compare of pair j,j+1
  logic swp [MaxRegions];
  always_comb begin
    for (int j = 0; j < MaxRegions; j++) begin
      swp[j] = 1'b0;
      if (j + 1 < MaxRegions && (j % 2) == int'(odd_r) && CntW'(j + 1) < wcnt_r)
        swp[j] = wk_s[j] > wk_s[j+1];
    end
  end

  logic [AddrW-1:0] room, clen;
  assign room = ~in_range_start;
  assign clen = (in_range_length > room) ? room : in_range_length;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r <= in_range_start;
      len_r <= clen;
      e_r <= in_range_start + clen;
      cur_r <= in_range_start;
      k_r <= in_range_kind;
    end
    if (push && !full_r && wcnt_r < CntW'(MaxRegions)) begin
      wk_s[wcnt_r[IdxW-1:0]] <= ps;
      wk_l[wcnt_r[IdxW-1:0]] <= pl;
      wk_k[wcnt_r[IdxW-1:0]] <= pk;
    end
    if (cmd.walk && idx_r < total_r && ovl && phase_r == 2'd3 && hi > cur_r)
      cur_r <= hi;
    if (cmd.sort) begin
      for (int j = 0; j + 1 < MaxRegions; j++) begin
        if (swp[j]) begin
          wk_s[j] <= wk_s[j+1]; wk_s[j+1] <= wk_s[j];
          wk_l[j] <= wk_l[j+1]; wk_l[j+1] <= wk_l[j];
          wk_k[j] <= wk_k[j+1]; wk_k[j+1] <= wk_k[j];
        end
      end
    end
    if (cmd.copy && !full_r) begin
      tbl_s[ri] <= wk_s[ri];
      tbl_l[ri] <= wk_l[ri];
      tbl_k[ri] <= wk_k[ri];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0; wcnt_r <= '0; idx_r <= '0; full_r <= 1'b0;
      ovf_r <= 1'b0; odd_r <= 1'b0; phase_r <= '0; pass_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.load) ovf_r <= 1'b0;
      if (cmd.clr) begin
        wcnt_r <= '0; idx_r <= '0; full_r <= 1'b0; phase_r <= '0;
        odd_r <= 1'b0; pass_r <= '0;
      end
      if (push) begin
        if (wcnt_r >= CntW'(MaxRegions)) full_r <= 1'b1;
        else wcnt_r <= wcnt_r + 1'b1;
      end
      if (cmd.walk && idx_r < total_r) begin
        if (adv) begin
          idx_r <= idx_r + 1'b1; phase_r <= '0;
        end else phase_r <= phase_r + 1'b1;
      end
      if (cmd.tail) idx_r <= '0;
      if (cmd.sort) begin
        odd_r <= ~odd_r;
        pass_r <= pass_r + 1'b1;
      end
      if (cmd.copy) begin
        idx_r <= sts.copy_done ? '0 : idx_r + 1'b1;
        if (full_r) ovf_r <= 1'b1;
        if (sts.copy_done && !full_r) total_r <= wcnt_r;
      end
      if (cmd.emit) begin
        idx_r <= sts.emit_done ? '0 : idx_r + 1'b1;
        out_entry_start <= (total_r == '0) ? '0 : rs;
        out_entry_length <= (total_r == '0) ? '0 : rl;
        out_entry_kind <= (total_r == '0) ? '0 : rk;
        out_entry_index <= (total_r == '0) ? 4'd0 : idx_r[3:0];
        out_last_entry <= sts.emit_done;
        out_table_empty <= (total_r == '0);
        out_overflow <= ovf_r;
      end
    end
  end

  assign sts.paint = (len_r != '0);
  assign sts.walk_done = cmd.walk && (idx_r >= total_r);
  assign sts.sort_done = (pass_r == IdxW'(MaxRegions - 1));
  assign sts.copy_done = full_r || (idx_r + 1'b1 >= CntW'(MaxRegions));
  assign sts.emit_done = (total_r == '0) || (idx_r + 1'b1 >= total_r);
endmodule
`default_nettype wire

// ----- hdl/rmru_chk.sv -----
`default_nettype none
module rmru_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_entry,
  input wire logic out_table_empty
);
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_entry |-> busy) else $error("beat after busy drop");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |-> out_last_entry) else $error("empty not last");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid) else $error("beat while idle");
endmodule

bind region_map_range_update_top rmru_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_last_entry(out_last_entry), .out_table_empty(out_table_empty)
);
`default_nettype wire
